// ----- rtl/csvt_pkg.sv -----
// csvt_pkg: shared types and constants of the CSV field tokenizer.
// Used by every module under rtl/; no dependencies of its own.

package csvt_pkg;

    localparam int MAX_ROWS    = 1000;
    localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SEP_RESET  = 8'd44;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_QUOTE   = 8'd34;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_SEMI    = 8'd59;

    // "&amp", "&gt", "&lt", newest byte lowest
    localparam logic [31:0] ENT_AMP = 32'h2661_6D70;
    localparam logic [23:0] ENT_GT  = 24'h26_6774;
    localparam logic [23:0] ENT_LT  = 24'h26_6C74;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       in_marker;
        logic       cell_end;
        logic       header_cell;
        logic       row_end;
        logic       last_of_run;
    } out_item_t;

    // all results caused by one input byte
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } q_entry_t;

endpackage

// ----- rtl/csvt_front.sv -----
// csvt_front: accepts bytes, tracks quote/cell/row state and classifies
// each byte into up to two result records. Depends on csvt_pkg.

module csvt_front
    import csvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    output logic      push,
    output q_entry_t  entry
);

    logic [7:0]           sep_reg;
    logic                 quoted_reg, quoted_next;
    logic [31:0]          recent_reg, recent_next;
    logic [2:0]           bic_reg, bic_next;
    logic                 prefix_reg, prefix_next;
    logic                 star_reg, star_next;
    logic                 has_reg, has_next;
    logic                 arb_reg, arb_next;
    logic [ROW_CNT_W-1:0] rows_reg, rows_next;

    logic [7:0] b;
    logic       eob, active, brk, ent, content, row_done, ce_emit, eob_emit, im;
    out_item_t  ce_res, ct_res, eob_res, first_res;
    logic       first_v;

    always_comb
    begin
        b      = item.in_byte;
        eob    = item.end_of_buffer;
        active = rows_reg < ROW_CNT_W'(MAX_ROWS);
        brk    = (b == CH_LF) || (b == CH_CR);
        ent    = ((bic_reg >= 3'd4) && (recent_reg == ENT_AMP)) ||
                 ((bic_reg >= 3'd3) &&
                  ((recent_reg[23:0] == ENT_GT) || (recent_reg[23:0] == ENT_LT)));

        content  = 1'b0;
        ce_emit  = 1'b0;
        row_done = 1'b0;

        quoted_next = quoted_reg;
        recent_next = recent_reg;
        bic_next    = bic_reg;
        prefix_next = prefix_reg;
        star_next   = star_reg;
        has_next    = has_reg;
        arb_next    = arb_reg;
        rows_next   = rows_reg;

        ce_res             = '0;
        ce_res.cell_end    = 1'b1;
        ce_res.header_cell = star_reg;
        ce_res.row_end     = brk;

        if (b == CH_QUOTE)
        begin
            quoted_next = ~quoted_reg;
            content     = 1'b1;
        end
        else if (quoted_reg)
            content = 1'b1;
        else if ((b == CH_SEMI) && ent)
            content = 1'b1;
        else if (brk)
        begin
            if (!arb_reg)
            begin
                ce_emit  = 1'b1;
                row_done = 1'b1;
                arb_next = 1'b1;
                rows_next = rows_reg + 1'b1;
            end
        end
        else if (b == sep_reg)
        begin
            ce_emit  = 1'b1;
            arb_next = 1'b0;
        end
        else
            content = 1'b1;

        if (ce_emit)
        begin
            recent_next = '0;
            bic_next    = '0;
            prefix_next = 1'b1;
            star_next   = 1'b0;
            has_next    = 1'b0;
        end

        im = prefix_reg && ((b == CH_STAR) || (b == CH_SPACE));
        if (content)
        begin
            if (im && (b == CH_STAR))
                star_next = 1'b1;
            if (!im)
                prefix_next = 1'b0;
            recent_next = {recent_reg[23:0], b};
            if (bic_reg < 3'd4)
                bic_next = bic_reg + 3'd1;
            has_next = 1'b1;
            arb_next = 1'b0;
        end

        ct_res            = '0;
        ct_res.byte_valid = 1'b1;
        ct_res.out_byte   = b;
        ct_res.in_marker  = im;

        // buffer end closes an unfinished row
        eob_res  = '0;
        eob_emit = 1'b0;
        if (eob && !row_done)
        begin
            if (has_next)
            begin
                eob_emit            = 1'b1;
                eob_res.cell_end    = 1'b1;
                eob_res.header_cell = star_next;
                eob_res.row_end     = 1'b1;
            end
            else if (!arb_next)
            begin
                eob_emit        = 1'b1;
                eob_res.row_end = 1'b1;
            end
        end
        eob_res.last_of_run = 1'b1;

        first_v   = ce_emit || content;
        first_res = ce_emit ? ce_res : ct_res;
        first_res.last_of_run = !eob_emit;

        entry = '0;
        if (first_v)
        begin
            entry.first  = first_res;
            entry.second = eob_res;
            entry.two    = eob_emit;
        end
        else
            entry.first = eob_res;

        push = accept && active && (first_v || eob_emit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= SEP_RESET;
            quoted_reg <= 1'b0;
            recent_reg <= '0;
            bic_reg    <= '0;
            prefix_reg <= 1'b1;
            star_reg   <= 1'b0;
            has_reg    <= 1'b0;
            arb_reg    <= 1'b0;
            rows_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                sep_reg <= cfg_data;
            if (accept)
            begin
                if (eob)
                begin
                    quoted_reg <= 1'b0;
                    recent_reg <= '0;
                    bic_reg    <= '0;
                    prefix_reg <= 1'b1;
                    star_reg   <= 1'b0;
                    has_reg    <= 1'b0;
                    arb_reg    <= 1'b0;
                    rows_reg   <= '0;
                end
                else if (active)
                begin
                    quoted_reg <= quoted_next;
                    recent_reg <= recent_next;
                    bic_reg    <= bic_next;
                    prefix_reg <= prefix_next;
                    star_reg   <= star_next;
                    has_reg    <= has_next;
                    arb_reg    <= arb_next;
                    rows_reg   <= rows_next;
                end
            end
        end
    end

endmodule

// ----- rtl/csvt_queue.sv -----
// csvt_queue: small FIFO of per-byte result entries between front and back.
// Depends on csvt_pkg for the entry type and depth.

module csvt_queue
    import csvt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty,
    output logic     full
);

    q_entry_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full |-> pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/csvt_back.sv -----
// csvt_back: drains queue entries and presents results one per transfer
// through an output register. Depends on csvt_pkg.

module csvt_back
    import csvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_entry_t  head,
    input  logic      empty,
    output logic      pop,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_data
);

    logic      out_valid_reg;
    out_item_t out_reg;
    logic      pend_valid_reg;
    out_item_t pend_reg;
    logic      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = out_free && !pend_valid_reg && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= !empty;
                pend_valid_reg <= !empty && head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
                out_reg <= pend_reg;
            else if (!empty)
            begin
                out_reg  <= head.first;
                pend_reg <= head.second;
            end
        end
    end

    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result held without a first one shown");

    a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_reg.last_of_run)
        else $error("held second result not marked last");

    a_nonlast_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last_of_run |-> pend_valid_reg)
        else $error("non-last result without a follower");

endmodule

// ----- rtl/csv_field_tokenizer_top.sv -----
// CSV field tokenizer: one text byte per transfer on the input channel,
// cell/row result records on the output channel. Separator register on cfg.
//
// Channels: in_valid/in_ready/in_data (byte plus end-of-buffer flag),
// out_valid/out_ready/out_data (one result per transfer), and the
// separator write channel cfg_valid/cfg_ready/cfg_data (always ready).
// Each byte yields zero, one or two results; last_of_run marks the final
// one of a byte. Bytes after the row limit and skipped line breaks yield
// none.
// The first result of a byte is written into the queue and then registered
// in the output stage. Throughput: one byte per cycle while each byte yields
// at most one result and out_ready stays high; the output register moves one
// result per cycle, so a byte with two results takes an extra output transfer.
// The four-entry queue between the classifier and the output stage absorbs
// that and receiver stalls; in_ready drops only when the queue is full.
// Reset clears the separator to ',' and all cell, row and quote state.
// Depends on csvt_pkg, csvt_front, csvt_queue, csvt_back.

module csv_field_tokenizer_top
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic     push, pop, empty, full;
    q_entry_t entry, head;

    assign in_ready  = !full;
    assign cfg_ready = 1'b1;

    csvt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_valid && in_ready),
        .item     (in_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .push     (push),
        .entry    (entry)
    );

    csvt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    csvt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- verif/csv_field_tokenizer_top_test.sv -----
// Testbench for csv_field_tokenizer_top: streams text bytes through the tokenizer and
// checks every cell/row result against a behavioral predictor kept in step with each transfer.
// Depends on csvt_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module csv_field_tokenizer_top_test;
    import csvt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 145;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    csv_field_tokenizer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the tokenizer state
    logic [7:0]  sep_reg;
    bit          quoted;
    logic [31:0] recent;
    int unsigned cell_len;
    bit          in_prefix;
    bit          star_seen;
    bit          cell_has_bytes;
    bit          after_break;
    int unsigned rows_done;

    out_item_t   pending_tokens[$];

    bit          calm;
    int          stall_request;
    int          error_count;
    int          cycle_count;
    int          bytes_sent;
    int          buffers_sent;
    int          separators_used;
    int          tokens_checked;
    int          cells_seen;
    int          rows_seen;
    int          header_cells;
    int          bytes_past_limit;
    int          input_stall_cycles;
    int          long_stalls;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_tokens.size());
            $display("[csv_field_tokenizer_top] ERROR");
            $finish;
        end
    end

    function automatic void start_new_cell();
        recent = '0;
        cell_len = 0;
        in_prefix = 1;
        star_seen = 0;
        cell_has_bytes = 0;
    endfunction

    function automatic void start_new_buffer();
        start_new_cell();
        quoted = 0;
        after_break = 0;
        rows_done = 0;
    endfunction

    function automatic bit closes_entity();
        if (cell_len >= 4 && recent == ENT_AMP)
            return 1;
        if (cell_len >= 3 && (recent[23:0] == ENT_GT || recent[23:0] == ENT_LT))
            return 1;
        return 0;
    endfunction

    function automatic out_item_t make_token(bit bv, logic [7:0] ob, bit im, bit ce, bit hc,
                                             bit re);
        out_item_t t;
        t = '0;
        t.byte_valid = bv;
        t.out_byte = ob;
        t.in_marker = im;
        t.cell_end = ce;
        t.header_cell = hc;
        t.row_end = re;
        return t;
    endfunction

    // expected results of one accepted byte, appended to pending_tokens
    function automatic void predict_byte(logic [7:0] b, bit eob);
        out_item_t toks[$];
        bit content;
        bit row_done;
        bit is_break;
        bit marker;
        content = 0;
        row_done = 0;
        is_break = (b == CH_LF || b == CH_CR);
        if (rows_done < MAX_ROWS)
        begin
            if (b == CH_QUOTE)
            begin
                quoted = !quoted;
                content = 1;
            end
            else if (quoted)
                content = 1;
            else if (b == CH_SEMI && closes_entity())
                content = 1;
            else if (is_break)
            begin
                // only the first break of a run ends the row
                if (!after_break)
                begin
                    toks.push_back(make_token(0, 8'h00, 0, 1, star_seen, 1));
                    start_new_cell();
                    after_break = 1;
                    rows_done++;
                    row_done = 1;
                end
            end
            else if (b == sep_reg)
            begin
                toks.push_back(make_token(0, 8'h00, 0, 1, star_seen, 0));
                start_new_cell();
                after_break = 0;
            end
            else
                content = 1;

            if (content)
            begin
                marker = in_prefix && (b == CH_STAR || b == CH_SPACE);
                if (marker && b == CH_STAR)
                    star_seen = 1;
                if (!marker)
                    in_prefix = 0;
                recent = {recent[23:0], b};
                if (cell_len < 4)
                    cell_len++;
                cell_has_bytes = 1;
                after_break = 0;
                toks.push_back(make_token(1, b, marker, 0, 0, 0));
            end

            // buffer end closes an open row; an empty last cell is dropped
            if (eob && !row_done)
            begin
                if (cell_has_bytes)
                    toks.push_back(make_token(0, 8'h00, 0, 1, star_seen, 1));
                else if (!after_break)
                    toks.push_back(make_token(0, 8'h00, 0, 0, 0, 1));
            end
        end
        else
            bytes_past_limit++;

        if (eob)
            start_new_buffer();
        if (toks.size() > 0)
            toks[toks.size() - 1].last_of_run = 1;
        foreach (toks[i])
            pending_tokens.push_back(toks[i]);
    endfunction

    task automatic flag_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic check_token(input out_item_t got);
        out_item_t want;
        if (pending_tokens.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing expected: %p", got));
        end
        else
        begin
            want = pending_tokens.pop_front();
            check_field("byte_valid", got.byte_valid, want.byte_valid);
            check_field("out_byte", got.out_byte, want.out_byte);
            check_field("in_marker", got.in_marker, want.in_marker);
            check_field("cell_end", got.cell_end, want.cell_end);
            check_field("header_cell", got.header_cell, want.header_cell);
            check_field("row_end", got.row_end, want.row_end);
            check_field("last_of_run", got.last_of_run, want.last_of_run);
        end
        tokens_checked++;
        if (got.cell_end)
            cells_seen++;
        if (got.row_end)
            rows_seen++;
        if (got.cell_end && got.header_cell)
            header_cells++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_token(out_data);
        if (rst_n && in_valid && !in_ready)
            input_stall_cycles++;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // result side: random hold-offs per transfer, or a long one when asked
    initial
    begin : receiver
        int gap;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_request > 0)
            begin
                gap = stall_request;
                stall_request = 0;
                long_stalls++;
            end
            else
                gap = draw_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit eob);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data.in_byte <= b;
        in_data.end_of_buffer <= eob;
        do @(posedge clk); while (!in_ready);
        predict_byte(b, eob);
        bytes_sent++;
        if (eob)
            buffers_sent++;
    endtask

    task automatic send_text(input string s, input bit eob_on_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eob_on_last && (i == s.len() - 1));
    endtask

    // input idle, all results in, and any resultless byte flushed
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_separator(input logic [7:0] value);
        settle_block();
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sep_reg = value;
        separators_used++;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic test_field_extremes();
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        // leading line break, then a skipped break that also ends the buffer
        send_byte(CH_LF, 0);
        send_byte(CH_CR, 1);
    endtask

    task automatic test_header_and_entity();
        send_text("* *a,&amp;", 0);
        // separator then buffer end: the empty last cell is dropped
        send_text(",", 1);
    endtask

    task automatic test_quoted_breaks();
        send_text("\"x,\n\"", 0);
        send_byte(CH_LF, 1);
    endtask

    task automatic send_random_segment(output int count);
        byte unsigned seg[$];
        string s;
        int kind;
        int n;
        bit eob;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
                seg.push_back(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                             : $urandom_range(97, 122)));
        end
        else if (kind < 40)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                seg.push_back($urandom_range(0, 1) ? CH_STAR : CH_SPACE);
            n = $urandom_range(0, 3);
            repeat (n)
                seg.push_back(8'($urandom_range(65, 90)));
        end
        else if (kind < 52)
        begin
            case ($urandom_range(0, 6))
                0: s = "&amp;";
                1: s = "&gt;";
                2: s = "&lt;";
                3: s = "&am;";
                4: s = "x&lt;";
                5: s = "&gp;";
                default: s = "a;";
            endcase
            for (int i = 0; i < s.len(); i++)
                seg.push_back(s[i]);
        end
        else if (kind < 62)
        begin
            // quoted run holding bytes that would otherwise split
            seg.push_back(CH_QUOTE);
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 4))
                    0: seg.push_back(sep_reg);
                    1: seg.push_back(CH_CR);
                    2: seg.push_back(CH_LF);
                    3: seg.push_back(CH_SEMI);
                    default: seg.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 9) != 0)
                seg.push_back(CH_QUOTE);
        end
        else if (kind < 80)
            seg.push_back(sep_reg);
        else if (kind < 93)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                seg.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                seg.push_back(8'($urandom_range(0, 255)));
        end

        eob = ($urandom_range(0, 29) == 0);
        foreach (seg[i])
            send_byte(seg[i], eob && (i == seg.size() - 1));
        count = seg.size();
    endtask

    task automatic test_random_text();
        logic [7:0] seps[10];
        int sent;
        int n;
        seps = '{8'h00, 8'hFF, CH_QUOTE, CH_CR, CH_LF, CH_SEMI, 8'h09, 8'h00, 8'h7C, SEP_RESET};
        seps[7] = 8'($urandom_range(0, 255));
        foreach (seps[p])
        begin
            write_separator(seps[p]);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                if ($urandom_range(0, 19) == 0)
                    calm = !calm;
                send_random_segment(n);
                sent += n;
            end
        end
        calm = 0;
    endtask

    task automatic test_output_backpressure();
        settle_block();
        calm = 1;
        stall_request = 80;
        for (int i = 0; i < 8; i++)
            send_text("ab,c\n", 0);
        calm = 0;
    endtask

    task automatic test_row_limit();
        settle_block();
        calm = 1;
        send_byte("q", 1);
        for (int i = 0; i < MAX_ROWS + 2; i++)
            send_text("r\n", 0);
        // past the limit: nothing until the buffer ends, then a fresh buffer works
        send_text("x,y", 1);
        send_text("z", 1);
        calm = 0;
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_data = '0;
        calm = 0;
        stall_request = 0;
        sep_reg = SEP_RESET;
        start_new_buffer();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        test_field_extremes();
        test_header_and_entity();
        test_quoted_breaks();
        test_random_text();
        test_output_backpressure();
        test_row_limit();

        settle_block();
        repeat (12) @(posedge clk);
        $display("%0d bytes in %0d buffers over %0d separator settings, %0d results checked",
                 bytes_sent, buffers_sent, separators_used, tokens_checked);
        $display("%0d cells, %0d rows, %0d header cells, %0d bytes past row limit, %0d %s",
                 cells_seen, rows_seen, header_cells, bytes_past_limit, input_stall_cycles,
                 "input backpressure cycles");
        if (error_count == 0)
            $display("[csv_field_tokenizer_top] OK");
        else
            $display("[csv_field_tokenizer_top] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csvt_pkg.sv
rtl/csvt_front.sv
rtl/csvt_queue.sv
rtl/csvt_back.sv
rtl/csv_field_tokenizer_top.sv
verif/csv_field_tokenizer_top_test.sv
